/* rtl/core/ksle_pkg.sv */
// Shared types, constants and command codes for the keyed sequential list engine.
package ksle_pkg;

    // List storage geometry.
    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Fixed field widths of a transaction.
    localparam int CMD_W    = 3;
    localparam int POS_W    = 7;
    localparam int NAME_W   = 64;
    localparam int NUM_W    = 32;
    localparam int AGE_W    = 8;
    localparam int SCORE_W  = 16;
    localparam int STAT_W   = 2;
    localparam int ECOUNT_W = 7;

    // Width used to compare an insert position against the fill count.
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // Stream bus widths, packed fields padded to whole bytes.
    localparam int IN_BITS    = CMD_W + POS_W + 2 * NAME_W + NUM_W + AGE_W + SCORE_W;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = STAT_W + NAME_W + NUM_W + AGE_W + SCORE_W + ECOUNT_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_BITS;

    // One stored record.
    typedef struct packed {
        logic [NAME_W-1:0]  name;
        logic [NUM_W-1:0]   number;
        logic [AGE_W-1:0]   age;
        logic [SCORE_W-1:0] score;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT   = 3'd0,
        CMD_DEL_HEAD = 3'd1,
        CMD_DEL_TAIL = 3'd2,
        CMD_DEL_KEY  = 3'd3,
        CMD_LOCATE   = 3'd4,
        CMD_UPDATE   = 3'd5,
        CMD_PRIOR    = 3'd6,
        CMD_NEXT     = 3'd7
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_MISS    = 2'd1,
        STAT_BAD_POS = 2'd2,
        STAT_FULL    = 2'd3
    } t_stat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT_UP,
        ST_INS_WRITE,
        ST_SCAN,
        ST_FETCH,
        ST_FETCH_CAP,
        ST_SHIFT_DN,
        ST_FINISH
    } t_state;

endpackage

/* rtl/core/keyed_sequential_list_engine.sv */
// Inserts move the entries from the insert position on up by one place, then write the new
// record; lookups compare entries in order, prior and next then fetch the neighbour; removals
// fetch or find the entry, then move the later entries down by one place.
// One command at a time; the next is taken from the cycle after the result is loaded, and a full
// output register holds the sequencer until the waiting result is taken.
// Reset (synchronous, active low) empties the list and the output; storage is not cleared.
module keyed_sequential_list_engine (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // command, position, name_key, new_name, rec_number, rec_age, rec_score, zero pad
    input  logic [ksle_pkg::IN_DATA_W-1:0]  i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // status, out_name, out_number, out_age, out_score, entry_count, zero pad
    output logic [ksle_pkg::OUT_DATA_W-1:0] o_m_tdata
);

    import ksle_pkg::*;

    // Unpacked input fields.
    t_cmd                w_in_cmd;
    logic [POS_W-1:0]    w_in_pos;
    logic [NAME_W-1:0]   w_in_key;
    logic [NAME_W-1:0]   w_in_new;
    logic [NUM_W-1:0]    w_in_num;
    logic [AGE_W-1:0]    w_in_age;
    logic [SCORE_W-1:0]  w_in_score;

    assign w_in_cmd   = t_cmd'(i_s_tdata[2:0]);
    assign w_in_pos   = i_s_tdata[9:3];
    assign w_in_key   = i_s_tdata[73:10];
    assign w_in_new   = i_s_tdata[137:74];
    assign w_in_num   = i_s_tdata[169:138];
    assign w_in_age   = i_s_tdata[177:170];
    assign w_in_score = i_s_tdata[193:178];

    // Sequencer and datapath registers.
    t_state              r_state, n_state;
    t_cmd                r_cmd, n_cmd;
    logic [NAME_W-1:0]   r_key, n_key;
    t_rec                r_irec, n_irec;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_src, n_src;
    logic [CNT_W-1:0]    r_lim, n_lim;
    logic                r_iss, n_iss;
    logic                r_pend, n_pend;
    logic [ADDR_W-1:0]   r_wa, n_wa;
    logic [ADDR_W-1:0]   r_fidx, n_fidx;
    t_rec                r_res, n_res;
    t_stat               r_stat, n_stat;
    logic                r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    // RAM port signals.
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    t_rec                ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [REC_W-1:0]    ram_rdata_bits;
    t_rec                ram_rdata;

    // Decode helpers.
    logic [CMP_W-1:0]    w_pos_ext;
    logic [CMP_W-1:0]    w_cnt_ext;
    logic                w_bad_pos;
    logic                w_full;
    logic                w_empty;
    logic                w_hit;
    logic                w_accept;
    logic                w_out_load;
    logic [CNT_W-1:0]    w_wa_next;

    assign w_pos_ext  = CMP_W'(w_in_pos);
    assign w_cnt_ext  = CMP_W'(r_count);
    assign w_bad_pos  = (w_pos_ext == '0) || (w_pos_ext > (w_cnt_ext + CMP_W'(1)));
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign ram_rdata  = t_rec'(ram_rdata_bits);
    assign w_hit      = r_pend && (ram_rdata.name == r_key);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_load = (r_state == ST_FINISH) && (!r_out_valid || i_m_tready);
    assign w_wa_next  = CNT_W'(r_wa) + CNT_W'(1);

    // Record storage.
    ksle_ram #(
        .WIDTH (REC_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata_bits)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    unique case (w_in_cmd)
                        CMD_INSERT: begin
                            n_state = (w_bad_pos || w_full) ? ST_FINISH : ST_SHIFT_UP;
                        end
                        CMD_DEL_HEAD, CMD_DEL_TAIL: begin
                            n_state = w_empty ? ST_FINISH : ST_FETCH;
                        end
                        default: begin
                            n_state = ST_SCAN;
                        end
                    endcase
                end
            end
            ST_SHIFT_UP: begin
                if (!r_iss && !r_pend) begin
                    n_state = ST_INS_WRITE;
                end
            end
            ST_INS_WRITE: begin
                n_state = ST_FINISH;
            end
            ST_SCAN: begin
                if (w_hit) begin
                    priority case (r_cmd)
                        CMD_DEL_KEY:          n_state = ST_SHIFT_DN;
                        CMD_PRIOR, CMD_NEXT:  n_state = ST_FETCH;
                        default:              n_state = ST_FINISH;
                    endcase
                end else if (!r_iss && !r_pend) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FETCH: begin
                n_state = ST_FETCH_CAP;
            end
            ST_FETCH_CAP: begin
                if (r_cmd == CMD_DEL_HEAD || r_cmd == CMD_DEL_TAIL) begin
                    n_state = ST_SHIFT_DN;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_SHIFT_DN: begin
                if (!r_iss && !r_pend) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs, RAM control and datapath updates.
    always_comb begin
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_irec      = r_irec;
        n_count     = r_count;
        n_src       = r_src;
        n_lim       = r_lim;
        n_iss       = r_iss;
        n_pend      = r_pend;
        n_wa        = r_wa;
        n_fidx      = r_fidx;
        n_res       = r_res;
        n_stat      = r_stat;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        ram_we      = 1'b0;
        ram_waddr   = r_wa;
        ram_wdata   = ram_rdata;
        ram_re      = 1'b0;
        ram_raddr   = r_src[ADDR_W-1:0];
        o_s_tready  = 1'b0;

        // The output register drains independently of the sequencer.
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (w_accept) begin
                    n_cmd       = w_in_cmd;
                    n_key       = w_in_key;
                    n_irec.name = (w_in_cmd == CMD_INSERT) ? w_in_key : w_in_new;
                    n_irec.number = w_in_num;
                    n_irec.age    = w_in_age;
                    n_irec.score  = w_in_score;
                    n_pend      = 1'b0;
                    // A miss echoes the key with an otherwise empty record.
                    n_res       = '{name: w_in_key, number: '0, age: '0, score: '0};
                    n_stat      = STAT_MISS;
                    unique case (w_in_cmd)
                        CMD_INSERT: begin
                            n_res = '0;
                            if (w_bad_pos) begin
                                n_stat = STAT_BAD_POS;
                            end else if (w_full) begin
                                n_stat = STAT_FULL;
                            end else begin
                                n_stat = STAT_OK;
                            end
                            n_lim = CNT_W'(w_pos_ext - CMP_W'(1));
                            n_src = r_count - CNT_W'(1);
                            n_iss = (CMP_W'(r_count) != (w_pos_ext - CMP_W'(1)));
                        end
                        CMD_DEL_HEAD: begin
                            n_fidx = '0;
                            n_iss  = 1'b0;
                        end
                        CMD_DEL_TAIL: begin
                            n_fidx = ADDR_W'(r_count - CNT_W'(1));
                            n_iss  = 1'b0;
                        end
                        CMD_PRIOR: begin
                            n_src = CNT_W'(1);
                            n_lim = r_count;
                            n_iss = (r_count > CNT_W'(1));
                        end
                        CMD_NEXT: begin
                            n_src = '0;
                            n_lim = w_empty ? '0 : (r_count - CNT_W'(1));
                            n_iss = (r_count > CNT_W'(1));
                        end
                        default: begin
                            n_src = '0;
                            n_lim = r_count;
                            n_iss = !w_empty;
                        end
                    endcase
                end
            end

            // Move entries up by one place, last first, reading one ahead of the write.
            ST_SHIFT_UP: begin
                ram_re    = r_iss;
                ram_raddr = r_src[ADDR_W-1:0];
                ram_we    = r_pend;
                ram_waddr = r_wa;
                ram_wdata = ram_rdata;
                n_wa      = ADDR_W'(r_src + CNT_W'(1));
                n_pend    = r_iss;
                n_iss     = r_iss && (r_src != r_lim);
                n_src     = r_src - CNT_W'(1);
            end

            ST_INS_WRITE: begin
                ram_we    = 1'b1;
                ram_waddr = r_lim[ADDR_W-1:0];
                ram_wdata = r_irec;
                n_count   = r_count + CNT_W'(1);
            end

            // Key scan: one read issued and one compare a cycle.
            ST_SCAN: begin
                ram_re    = r_iss;
                ram_raddr = r_src[ADDR_W-1:0];
                n_wa      = r_src[ADDR_W-1:0];
                n_pend    = r_iss;
                n_iss     = r_iss && ((r_src + CNT_W'(1)) < r_lim);
                n_src     = r_src + CNT_W'(1);
                if (w_hit) begin
                    n_stat = STAT_OK;
                    n_res  = ram_rdata;
                    n_pend = 1'b0;
                    n_iss  = 1'b0;
                    priority case (r_cmd)
                        CMD_UPDATE: begin
                            ram_we    = 1'b1;
                            ram_waddr = r_wa;
                            ram_wdata = r_irec;
                        end
                        CMD_DEL_KEY: begin
                            n_src = w_wa_next;
                            n_iss = (w_wa_next < r_count);
                        end
                        CMD_PRIOR: begin
                            n_fidx = r_wa - ADDR_W'(1);
                        end
                        CMD_NEXT: begin
                            n_fidx = r_wa + ADDR_W'(1);
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_FETCH: begin
                ram_re    = 1'b1;
                ram_raddr = r_fidx;
            end

            ST_FETCH_CAP: begin
                n_stat = STAT_OK;
                n_res  = ram_rdata;
                n_src  = CNT_W'(r_fidx) + CNT_W'(1);
                n_iss  = ((CNT_W'(r_fidx) + CNT_W'(1)) < r_count);
                n_pend = 1'b0;
            end

            // Close the gap: move entries down by one place, first to last.
            ST_SHIFT_DN: begin
                ram_re    = r_iss;
                ram_raddr = r_src[ADDR_W-1:0];
                ram_we    = r_pend;
                ram_waddr = r_wa;
                ram_wdata = ram_rdata;
                n_wa      = ADDR_W'(r_src - CNT_W'(1));
                n_pend    = r_iss;
                n_iss     = r_iss && ((r_src + CNT_W'(1)) < r_count);
                n_src     = r_src + CNT_W'(1);
                if (!r_iss && !r_pend) begin
                    n_count = r_count - CNT_W'(1);
                end
            end

            ST_FINISH: begin
                if (w_out_load) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {{OUT_PAD_W{1'b0}}, ECOUNT_W'(r_count), r_res.score,
                                   r_res.age, r_res.number, r_res.name, r_stat};
                end
            end

            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_iss       <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_iss       <= n_iss;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_key      <= n_key;
        r_irec     <= n_irec;
        r_src      <= n_src;
        r_lim      <= n_lim;
        r_wa       <= n_wa;
        r_fidx     <= n_fidx;
        r_res      <= n_res;
        r_stat     <= n_stat;
        r_out_data <= n_out_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // The list never holds more than its depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("fill count beyond list depth");

    // A taken command keeps the input closed on the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_tready)
        else $error("command accepted while another is in work");

    // Storage is never written while the engine is idle or waiting to deliver.
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_FINISH) |-> !ram_we)
        else $error("storage write outside a command");

    // The fill count moves by at most one per cycle.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            ((r_count == $past(r_count) + CNT_W'(1)) || (r_count == $past(r_count) - CNT_W'(1))))
        else $error("fill count jumped");

endmodule

/* rtl/core/ksle_ram.sv */
// Generic single write port, single read port RAM with a registered read.
module ksle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
